// ===== hdl/wsd_pkg.sv =====
// Package: shared constants and types for the LED string driver.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam int LedCount  = 8;
  localparam int LedIdxW   = 3;
  localparam int BitIdxW   = 5;
  localparam int ColorW    = 32;
  localparam int TickW     = 16;
  localparam int CfgIdxW   = 3;

  localparam logic [TickW-1:0]   OneHighReset  = TickW'(700 / 5);
  localparam logic [TickW-1:0]   OneLowReset   = TickW'(800 / 5);
  localparam logic [TickW-1:0]   ZeroHighReset = TickW'(350 / 5);
  localparam logic [TickW-1:0]   ZeroLowReset  = TickW'(600 / 5);
  localparam logic [TickW-1:0]   GapReset      = TickW'(60000 / 5);
  localparam logic [BitIdxW-1:0] TopBit        = BitIdxW'(31);
  localparam logic [LedIdxW-1:0] LastLed       = LedIdxW'(LedCount - 1);

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_START = 3'd1,
    PH_HIGH1 = 3'd2,
    PH_HIGH0 = 3'd3,
    PH_LOW1  = 3'd4,
    PH_LOW0  = 3'd5,
    PH_TRAIL = 3'd6
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ONE_LOW   = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_ZERO_LOW  = 3'd3,
    CFG_GAP       = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

endpackage

`default_nettype wire

// ===== hdl/wsd_if.sv =====
// Interfaces: input item channel and result channel of the LED string driver.
`timescale 1ns / 1ps
`default_nettype none

interface wsd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [wsd_pkg::LedIdxW-1:0]     led_index;
  logic [wsd_pkg::ColorW-1:0]      color_word;

  modport source (output valid, action, led_index, color_word, input ready);
  modport sink   (input valid, action, led_index, color_word, output ready);
endinterface

interface wsd_out_if;
  logic valid;
  logic ready;
  logic data_level;
  logic in_gap;

  modport source (output valid, data_level, in_gap, input ready);
  modport sink   (input valid, data_level, in_gap, output ready);
endinterface

`default_nettype wire

// ===== hdl/ws2812_led_string_driver_core.sv =====
// Top level: one-wire LED string driver with colour store and bit timing sequencer.
// An accepted item's result is valid in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the output register is refilled in the cycle it
//   is taken, so in_ch.ready only drops while a result sits unread.
// Reset (rst_n low, synchronous): colour store cleared, timings to defaults,
//   sequencer to the leading latch gap with LED 0, bit 31, tick count zero.
`timescale 1ns / 1ps
`default_nettype none

module ws2812_led_string_driver_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  wsd_in_if.sink                            in_ch,
  wsd_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [wsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [wsd_pkg::TickW-1:0]    cfg_wdata
);

  // timing registers
  logic [wsd_pkg::TickW-1:0] one_high_r, one_low_r, zero_high_r, zero_low_r, gap_r;

  // sequencer state
  wsd_pkg::phase_t               phase_r, phase_nxt;
  logic [wsd_pkg::LedIdxW-1:0]   led_r, led_nxt;
  logic [wsd_pkg::BitIdxW-1:0]   bit_r, bit_nxt;
  logic [wsd_pkg::TickW-1:0]     cnt_r, cnt_nxt;
  logic [wsd_pkg::ColorW-1:0]    color_r [wsd_pkg::LedCount];

  // result register
  logic out_valid_r;
  logic level_r, level_nxt;
  logic gap_flag_r, gap_flag_nxt;

  logic                        accept;
  logic                        is_write;
  wsd_pkg::phase_t             ph_eff;
  logic [wsd_pkg::TickW-1:0]   cnt_eff;
  logic [wsd_pkg::TickW-1:0]   len_raw;
  logic [wsd_pkg::TickW-1:0]   len;
  logic [wsd_pkg::TickW:0]     cnt_inc;
  logic                        done;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_write    = (in_ch.action == wsd_pkg::ACT_WRITE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_high_r  <= wsd_pkg::OneHighReset;
      one_low_r   <= wsd_pkg::OneLowReset;
      zero_high_r <= wsd_pkg::ZeroHighReset;
      zero_low_r  <= wsd_pkg::ZeroLowReset;
      gap_r       <= wsd_pkg::GapReset;
    end else if (cfg_we) begin
      case (cfg_index)
        wsd_pkg::CFG_ONE_HIGH:  one_high_r  <= cfg_wdata;
        wsd_pkg::CFG_ONE_LOW:   one_low_r   <= cfg_wdata;
        wsd_pkg::CFG_ZERO_HIGH: zero_high_r <= cfg_wdata;
        wsd_pkg::CFG_ZERO_LOW:  zero_low_r  <= cfg_wdata;
        wsd_pkg::CFG_GAP:       gap_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the bit is sampled from the store on its first tick
  always_comb begin
    if (phase_r == wsd_pkg::PH_START) begin
      ph_eff  = color_r[led_r][bit_r] ? wsd_pkg::PH_HIGH1 : wsd_pkg::PH_HIGH0;
      cnt_eff = '0;
    end else begin
      ph_eff  = phase_r;
      cnt_eff = cnt_r;
    end
  end

  always_comb begin
    case (ph_eff)
      wsd_pkg::PH_HIGH1: len_raw = one_high_r;
      wsd_pkg::PH_HIGH0: len_raw = zero_high_r;
      wsd_pkg::PH_LOW1:  len_raw = one_low_r;
      wsd_pkg::PH_LOW0:  len_raw = zero_low_r;
      default:           len_raw = gap_r;
    endcase
    // a zero duration counts as one tick
    len     = (len_raw == '0) ? wsd_pkg::TickW'(1) : len_raw;
    cnt_inc = {1'b0, cnt_eff} + (wsd_pkg::TickW + 1)'(1);
    done    = (cnt_inc >= {1'b0, len});
  end

  always_comb begin
    phase_nxt    = phase_r;
    led_nxt      = led_r;
    bit_nxt      = bit_r;
    cnt_nxt      = cnt_r;
    level_nxt    = (phase_r == wsd_pkg::PH_HIGH1) || (phase_r == wsd_pkg::PH_HIGH0);
    gap_flag_nxt = (phase_r == wsd_pkg::PH_LEAD) || (phase_r == wsd_pkg::PH_TRAIL);
    if (!is_write) begin
      level_nxt    = (ph_eff == wsd_pkg::PH_HIGH1) || (ph_eff == wsd_pkg::PH_HIGH0);
      gap_flag_nxt = (ph_eff == wsd_pkg::PH_LEAD) || (ph_eff == wsd_pkg::PH_TRAIL);
      phase_nxt    = ph_eff;
      cnt_nxt      = cnt_inc[wsd_pkg::TickW-1:0];
      if (done) begin
        cnt_nxt = '0;
        case (ph_eff)
          wsd_pkg::PH_LEAD: begin
            led_nxt   = '0;
            bit_nxt   = wsd_pkg::TopBit;
            phase_nxt = wsd_pkg::PH_START;
          end
          wsd_pkg::PH_HIGH1: phase_nxt = wsd_pkg::PH_LOW1;
          wsd_pkg::PH_HIGH0: phase_nxt = wsd_pkg::PH_LOW0;
          wsd_pkg::PH_LOW1, wsd_pkg::PH_LOW0: begin
            if (bit_r != '0) begin
              bit_nxt   = bit_r - wsd_pkg::BitIdxW'(1);
              phase_nxt = wsd_pkg::PH_START;
            end else if (led_r != wsd_pkg::LastLed) begin
              led_nxt   = led_r + wsd_pkg::LedIdxW'(1);
              bit_nxt   = wsd_pkg::TopBit;
              phase_nxt = wsd_pkg::PH_START;
            end else begin
              phase_nxt = wsd_pkg::PH_TRAIL;
            end
          end
          default: begin
            led_nxt   = '0;
            bit_nxt   = wsd_pkg::TopBit;
            phase_nxt = wsd_pkg::PH_LEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsd_pkg::PH_LEAD;
      led_r   <= '0;
      bit_r   <= wsd_pkg::TopBit;
      cnt_r   <= '0;
      for (int i = 0; i < wsd_pkg::LedCount; i++) begin
        color_r[i] <= '0;
      end
    end else if (accept) begin
      phase_r <= phase_nxt;
      led_r   <= led_nxt;
      bit_r   <= bit_nxt;
      cnt_r   <= cnt_nxt;
      if (is_write) begin
        color_r[in_ch.led_index] <= in_ch.color_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      level_r    <= level_nxt;
      gap_flag_r <= gap_flag_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_level = level_r;
  assign out_ch.in_gap     = gap_flag_r;

endmodule

`default_nettype wire

// ===== hdl/wsd_checker.sv =====
// Checker: port-level assertions for the LED string driver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wsd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic data_level,
  input wire logic in_gap
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(data_level) && $stable(in_gap))
    else $error("stalled result changed");

  // every accepted item yields a result in the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // input side only stalls while an unread result blocks the output register
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output register free");

  // the line is never driven high inside a latch gap
  a_gap_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(data_level && in_gap))
    else $error("line high during latch gap");

endmodule

bind ws2812_led_string_driver_core wsd_checker u_wsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .data_level (out_ch.data_level),
  .in_gap     (out_ch.in_gap)
);

`default_nettype wire

// ===== bench/tb_ws2812_led_string_driver_core.sv =====
// Testbench: LED string driver, checked item by item against a line-level predictor.
`timescale 1ns / 1ps

module tb_ws2812_led_string_driver_core;
  import wsd_pkg::*;

  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic level;
    logic gap;
  } line_state_t;

  // Predicts the data line for every accepted item and checks the results in order.
  class line_level_board;
    logic [TickW-1:0]   one_high, one_low, zero_high, zero_low, gap_len;
    logic [ColorW-1:0]  colors [LedCount];
    phase_t             ph;
    logic [LedIdxW-1:0] led;
    logic [BitIdxW-1:0] bitpos;
    logic [TickW-1:0]   spent;
    line_state_t        pending_levels [$];
    int mismatches, strays, checked, reported, frames;

    function new();
      one_high  = OneHighReset;
      one_low   = OneLowReset;
      zero_high = ZeroHighReset;
      zero_low  = ZeroLowReset;
      gap_len   = GapReset;
      foreach (colors[i]) colors[i] = '0;
      ph         = PH_LEAD;
      led        = '0;
      bitpos     = TopBit;
      spent      = '0;
      mismatches = 0;
      strays     = 0;
      checked    = 0;
      reported   = 0;
      frames     = 0;
    endfunction

    function void set_timing(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] v);
      case (idx)
        CFG_ONE_HIGH:  one_high  = v;
        CFG_ONE_LOW:   one_low   = v;
        CFG_ZERO_HIGH: zero_high = v;
        CFG_ZERO_LOW:  zero_low  = v;
        CFG_GAP:       gap_len   = v;
        default: ;
      endcase
    endfunction

    // a zero register still holds the line for one tick
    function logic [TickW-1:0] hold_for(phase_t p);
      logic [TickW-1:0] d;
      case (p)
        PH_HIGH1: d = one_high;
        PH_HIGH0: d = zero_high;
        PH_LOW1:  d = one_low;
        PH_LOW0:  d = zero_low;
        default:  d = gap_len;
      endcase
      return (d == '0) ? TickW'(1) : d;
    endfunction

    function line_state_t line_now();
      line_state_t r;
      r.level = (ph == PH_HIGH1) || (ph == PH_HIGH0);
      r.gap   = (ph == PH_LEAD) || (ph == PH_TRAIL);
      return r;
    endfunction

    function void next_phase();
      case (ph)
        PH_LEAD: begin
          led    = '0;
          bitpos = TopBit;
          ph     = PH_START;
        end
        PH_HIGH1: ph = PH_LOW1;
        PH_HIGH0: ph = PH_LOW0;
        PH_LOW1, PH_LOW0: begin
          if (bitpos != '0) begin
            bitpos = bitpos - 1'b1;
            ph     = PH_START;
          end else if (led != LastLed) begin
            led    = led + 1'b1;
            bitpos = TopBit;
            ph     = PH_START;
          end else begin
            ph = PH_TRAIL;
          end
        end
        default: begin
          if (ph == PH_TRAIL) frames++;
          led    = '0;
          bitpos = TopBit;
          ph     = PH_LEAD;
        end
      endcase
    endfunction

    function void note_item(action_t act, logic [LedIdxW-1:0] idx, logic [ColorW-1:0] color);
      line_state_t r;
      if (act == ACT_WRITE) begin
        colors[idx] = color;
        pending_levels.push_back(line_now());
        return;
      end
      // the bit value is fetched on the first tick of the bit
      if (ph == PH_START) begin
        ph    = colors[led][bitpos] ? PH_HIGH1 : PH_HIGH0;
        spent = '0;
      end
      r     = line_now();
      spent = spent + 1'b1;
      if (spent >= hold_for(ph)) begin
        spent = '0;
        next_phase();
      end
      pending_levels.push_back(r);
    endfunction

    function void check_level(logic level, logic gap);
      line_state_t want;
      if (pending_levels.size() == 0) begin
        strays++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] result with nothing pending: level=%b gap=%b", $time, level, gap);
        end
        return;
      end
      want = pending_levels.pop_front();
      checked++;
      if (level !== want.level || gap !== want.gap) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] result %0d: expected level=%b gap=%b, got level=%b gap=%b",
                   $time, checked, want.level, want.gap, level, gap);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TickW-1:0] cfg_wdata;
  logic steady = 1'b0;
  int quiet = 0;
  int sent = 0;
  line_level_board sb;

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  ws2812_led_string_driver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_level(out_ch.data_level, out_ch.in_gap);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("watchdog: no item moved for %0d cycles", QuietLimit);
      $display("FAIL ws2812_led_string_driver_core");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(action_t act, logic [LedIdxW-1:0] idx, logic [ColorW-1:0] color);
    int pause;
    pause = 0;
    if (!steady && $urandom_range(99) < 10) pause = $urandom_range(1, 5);
    if (pause != 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.led_index  <= idx;
    in_ch.color_word <= color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(act, idx, color);
    sent++;
  endtask

  task automatic send_random(int wr_pct);
    action_t act;
    logic [ColorW-1:0] color;
    act = ($urandom_range(99) < wr_pct) ? ACT_WRITE : ACT_TICK;
    case ($urandom_range(9))
      0:       color = '0;
      1:       color = '1;
      default: color = $urandom();
    endcase
    send_item(act, LedIdxW'($urandom_range(LedCount - 1)), color);
  endtask

  // stop sending and wait for every pending result, plus the pipeline latency
  task automatic settle_line();
    in_ch.valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // block must be idle; also pokes one unused index, which must change nothing
  task automatic write_timing(logic [TickW-1:0] vals [5]);
    for (int r = 0; r < 5; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxW'(r);
      cfg_wdata <= vals[r];
      @(posedge clk);
      sb.set_timing(CfgIdxW'(r), vals[r]);
    end
    cfg_index <= CfgIdxW'(CFG_GAP + $urandom_range(1, 3));
    cfg_wdata <= TickW'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [TickW-1:0] vals [5];
    int n;
    int wr_pct;

    sb = new();
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_TICK;
    in_ch.led_index  <= '0;
    in_ch.color_word <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // default timings: still inside the leading latch gap
    send_item(ACT_TICK, 3'd0, '0);
    send_item(ACT_WRITE, 3'd0, '1);
    send_item(ACT_WRITE, 3'(LastLed), '0);
    send_item(ACT_TICK, 3'd0, '0);
    send_item(ACT_TICK, 3'd0, '0);
    settle_line();

    // zero high time on a one bit, zero gap: both act as a single tick
    vals = '{16'd0, 16'd1, 16'd2, 16'd1, 16'd0};
    write_timing(vals);
    send_item(ACT_TICK, 3'd0, '0);
    // a write while the next bit has not started reads back low, not in a gap
    send_item(ACT_WRITE, 3'd1, 32'h8000_0001);
    repeat (8) send_item(ACT_TICK, 3'd0, '0);
    send_item(ACT_WRITE, 3'd0, '0);
    send_item(ACT_WRITE, 3'(LastLed), '1);
    repeat (8) send_item(ACT_TICK, 3'd0, '0);

    for (int p = 0; p < 6; p++) begin
      settle_line();
      wr_pct = 8;
      steady <= 1'b0;
      case (p)
        0: begin
          vals = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
          n = 120;
        end
        1: begin
          vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
          n = 120;
          steady <= 1'b1;
        end
        2: begin
          foreach (vals[i]) vals[i] = TickW'($urandom_range(4));
          n = 120;
        end
        3: begin
          vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
          n = 40;
          wr_pct = 30;
        end
        4: begin
          foreach (vals[i]) vals[i] = TickW'($urandom_range(1, 3));
          n = 120;
        end
        default: begin
          foreach (vals[i]) vals[i] = TickW'($urandom_range(3));
          vals[4] = TickW'($urandom_range(1, 20));
          n = 120;
        end
      endcase
      write_timing(vals);
      for (int k = 0; k < n; k++) begin
        // hold the sender off until the line has caught up
        if (p == 2 && k == 60) settle_line();
        send_random(wr_pct);
      end
    end

    steady <= 1'b0;
    in_ch.valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d items over six timing settings; %0d results checked, %0d frames completed",
             sent, sb.checked, sb.frames);
    $display("Mismatches %0d, unexpected results %0d, results still owed %0d",
             sb.mismatches, sb.strays, sb.pending_levels.size());
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending_levels.size() == 0) begin
      $display("PASS ws2812_led_string_driver_core");
    end else begin
      $display("FAIL ws2812_led_string_driver_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wsd_pkg.sv
hdl/wsd_if.sv
hdl/ws2812_led_string_driver_core.sv
hdl/wsd_checker.sv
bench/tb_ws2812_led_string_driver_core.sv
